[rtl/core/armpr_pkg.sv]
// Package for the aging-register MRU page replacer.
// Holds sizes, payload types and the scan / command structs shared by the cells and top level.
// No dependencies.
package armpr_pkg;

   localparam int NUM_FRAMES = 8;
   localparam int PAGE_BITS  = 16;
   localparam int AGE_BITS   = 8;

   localparam int IDX_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_BITS = $clog2(NUM_FRAMES + 1);

   // Fixed field widths of the channels and the register
   localparam int PAGE_FIELD_BITS  = 16;
   localparam int FRAME_FIELD_BITS = 3;
   localparam int FAULT_BITS       = 32;
   localparam int CSR_BITS         = 4;

   localparam logic [CSR_BITS-1:0]   CSR_RESET = CSR_BITS'(8);
   localparam logic [AGE_BITS-1:0]   AGE_TOP   = {1'b1, {(AGE_BITS-1){1'b0}}};
   localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [AGE_BITS-1:0]  age_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   // Running result handed from cell to cell
   typedef struct packed {
      logic     hit_found;
      idx_type  hit_idx;
      logic     empty_found;
      idx_type  empty_idx;
      logic     any;
      age_type  max_age;
      idx_type  max_idx;
      page_type max_page;
   } scan_type;

   // Update broadcast to every cell when a request is taken
   typedef struct packed {
      logic    step;
      logic    hit;
      idx_type slot;
   } cmd_type;

endpackage

[rtl/core/armpr_req_if.sv]
// Request channel: one page reference per transfer.
// Depends on armpr_pkg for the field widths.
interface armpr_req_if
   import armpr_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [PAGE_FIELD_BITS-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

[rtl/core/armpr_rsp_if.sv]
// Response channel: hit or fault, frame used, evicted page and fault count.
// Depends on armpr_pkg for the field widths.
interface armpr_rsp_if
   import armpr_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [FRAME_FIELD_BITS-1:0] frame_index;
   logic                        evicted_valid;
   logic [PAGE_FIELD_BITS-1:0]  evicted_page;
   logic [FAULT_BITS-1:0]       fault_count;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_count, input ready);
   modport sink (input valid, input hit, input frame_index, input evicted_valid,
                 input evicted_page, input fault_count, output ready);
endinterface

[rtl/core/aging_register_mru_page_replacer.sv]
// Aging-register page replacer evicting the most recently used frame (largest age).
// The response is registered when the request is taken.
// Throughput: 1 request per cycle while the output register is empty or being read;
// the frame cells finish lookup, aging and victim selection in the accepting cycle.
// Reset: clears frame valid bits, ages, fault count and output valid; active_frames
// returns to 8. Page contents are written before they are ever read.
module aging_register_mru_page_replacer
   import armpr_pkg::*;
   (
   input  logic                clock,
   input  logic                reset,
   armpr_req_if.sink           req_bus,
   armpr_rsp_if.source         rsp_bus,
   input  logic                csr_wr_en,
   input  logic [CSR_BITS-1:0] csr_wr_data
   );

   logic [CSR_BITS-1:0] active_frames_ff;
   cnt_type             frame_count;

   scan_type            scan [0:NUM_FRAMES];
   cmd_type             cmd;
   page_type            req_page;
   logic                step;
   logic                miss_evict;
   idx_type             slot;

   logic                        rsp_valid_ff;
   logic                        hit_ff;
   logic [FRAME_FIELD_BITS-1:0] frame_index_ff;
   logic                        evicted_valid_ff;
   logic [PAGE_FIELD_BITS-1:0]  evicted_page_ff;
   logic [FAULT_BITS-1:0]       fault_ff;
   logic [FAULT_BITS-1:0]       fault_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_frames_ff <= CSR_RESET;
      end else if (csr_wr_en) begin
         active_frames_ff <= csr_wr_data;
      end
   end

   // zero counts as one frame, anything past the array as all frames
   always_comb begin
      if (active_frames_ff == '0) begin
         frame_count = CNT_BITS'(1);
      end else if (32'(active_frames_ff) > NUM_FRAMES) begin
         frame_count = CNT_BITS'(NUM_FRAMES);
      end else begin
         frame_count = CNT_BITS'(active_frames_ff);
      end
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign step          = req_bus.valid && req_bus.ready;
   assign req_page      = PAGE_BITS'(req_bus.page_number);

   assign scan[0] = '0;

   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      armpr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_BITS'(g)),
         .active   (CNT_BITS'(g) < frame_count),
         .page_in  (req_page),
         .cmd      (cmd),
         .scan_in  (scan[g]),
         .scan_out (scan[g+1])
      );
   end

   assign miss_evict = !scan[NUM_FRAMES].hit_found && !scan[NUM_FRAMES].empty_found;

   always_comb begin
      if (scan[NUM_FRAMES].hit_found) begin
         slot = scan[NUM_FRAMES].hit_idx;
      end else if (scan[NUM_FRAMES].empty_found) begin
         slot = scan[NUM_FRAMES].empty_idx;
      end else begin
         slot = scan[NUM_FRAMES].max_idx;
      end
   end

   assign cmd.step = step;
   assign cmd.hit  = scan[NUM_FRAMES].hit_found;
   assign cmd.slot = slot;

   // saturate the fault total
   always_comb begin
      fault_in = fault_ff;
      if (!scan[NUM_FRAMES].hit_found && (fault_ff != FAULT_MAX)) begin
         fault_in = fault_ff + FAULT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fault_ff     <= '0;
      end else begin
         if (step) begin
            rsp_valid_ff <= 1'b1;
            fault_ff     <= fault_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hit_ff           <= scan[NUM_FRAMES].hit_found;
         frame_index_ff   <= FRAME_FIELD_BITS'(slot);
         evicted_valid_ff <= miss_evict;
         evicted_page_ff  <= miss_evict ? PAGE_FIELD_BITS'(scan[NUM_FRAMES].max_page)
                                        : '0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = hit_ff;
   assign rsp_bus.frame_index   = frame_index_ff;
   assign rsp_bus.evicted_valid = evicted_valid_ff;
   assign rsp_bus.evicted_page  = evicted_page_ff;
   assign rsp_bus.fault_count   = fault_ff;

endmodule

[rtl/core/armpr_cell.sv]
// One frame of the replacer: page, valid bit and age register.
// Extends the scan from its left neighbor and applies the broadcast update.
// Depends on armpr_pkg.
module armpr_cell
   import armpr_pkg::*;
   (
   input  logic     clock,
   input  logic     reset,
   input  idx_type  cell_idx,
   input  logic     active,
   input  page_type page_in,
   input  cmd_type  cmd,
   input  scan_type scan_in,
   output scan_type scan_out
   );

   page_type page_ff;
   logic     valid_ff;
   age_type  age_ff;

   age_type  aged;
   logic     match;
   logic     sel;

   assign aged  = age_ff >> 1;
   assign match = active && valid_ff && (page_ff == page_in);
   assign sel   = cmd.slot == cell_idx;

   always_comb begin
      scan_out = scan_in;
      if (active) begin
         if (match && !scan_in.hit_found) begin
            scan_out.hit_found = 1'b1;
            scan_out.hit_idx   = cell_idx;
         end
         if (!valid_ff && !scan_in.empty_found) begin
            scan_out.empty_found = 1'b1;
            scan_out.empty_idx   = cell_idx;
         end
         // strict compare keeps the lowest index on a tie
         if (!scan_in.any || (aged > scan_in.max_age)) begin
            scan_out.any      = 1'b1;
            scan_out.max_age  = aged;
            scan_out.max_idx  = cell_idx;
            scan_out.max_page = page_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
      end else if (cmd.step && active) begin
         if (sel && cmd.hit) begin
            age_ff <= aged | AGE_TOP;
         end else if (sel) begin
            age_ff   <= AGE_TOP;
            valid_ff <= 1'b1;
         end else begin
            age_ff <= aged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && active && sel && !cmd.hit) begin
         page_ff <= page_in;
      end
   end

endmodule
